FILE: src/ncomix_pkg.sv
// ----------------------------------------------------------------------------
// NCO mixer package
// Shared constants, types and the quarter-wave sine table generator for the
// real-to-IQ downconversion mixer.
// ----------------------------------------------------------------------------
package ncomix_pkg;

  // Default configuration of the mixer.
  localparam int SAMPLE_WIDTH_DEF    = 16;
  localparam int PHASE_WIDTH_DEF     = 32;
  localparam int TABLE_ADDR_BITS_DEF = 10;

  // Width of the phase step register.
  localparam int STEP_W = 32;

  // Sine coefficients are Q1.15 magnitudes up to COEF_MAX.
  localparam int COEF_W = 16;
  localparam longint unsigned COEF_MAX = 64'd32767;

  // Q30 fixed-point constants for the table generator.
  localparam longint unsigned PI_Q30   = 64'd3373259426;
  localparam longint unsigned HALF_Q30 = 64'd1 << 29;

  // Denominators (2n)*(2n+1) of the sine Taylor series terms.
  localparam longint unsigned TAYLOR_DEN [1:8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  typedef logic [COEF_W-1:0]        coef_mag_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  // Entry k of a quarter-wave sine table addressed by tab_bits phase bits:
  // round(32767 * sin(pi/2 * (k + 0.5) / depth)), evaluated with an integer
  // Q30 Taylor series. Used only at elaboration.
  function automatic coef_mag_t qsin_entry(input int unsigned k,
                                           input int unsigned tab_bits);
    logic [63:0] ang;
    logic [63:0] ang2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] sum;
    logic [63:0] v;
    int          n;
    // The full period spans 4 * depth = 2^tab_bits steps of the angle.
    ang  = (PI_Q30 * (64'(2 * k) + 64'd1)) >> tab_bits;
    ang2 = (ang * ang) >> 30;
    term = ang;
    pos  = ang;
    neg  = 64'd0;
    for (n = 1; n <= 8; n++) begin
      term = ((term * ang2) >> 30) / TAYLOR_DEN[n];
      if (n % 2 == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    sum = (pos > neg) ? (pos - neg) : 64'd0;
    v   = (sum * COEF_MAX + HALF_Q30) >> 30;
    if (v > COEF_MAX) begin
      v = COEF_MAX;
    end
    return v[COEF_W-1:0];
  endfunction

endpackage

FILE: src/nco_real_to_iq_mixer.sv
// Pipeline: an accepted item loads the ROM read stage, then the multiply stage
// and then the round and saturate stage, which drives out_*.
// Throughput: one item per cycle unless out_ready stalls the output; the two
// read ports of the sine ROM serve cosine and sine of the same phase together.
// Reset: rst_n clears the phase accumulator, the phase step and all stage
// valid bits; the sine ROM is constant and needs no fill pass.
// ----------------------------------------------------------------------------
// NCO real-to-IQ mixer
// Multiplies each real sample by e^(-j*theta) from a phase accumulator and a
// quarter-wave sine ROM, and returns rounded, saturated I and Q samples.
// ----------------------------------------------------------------------------
module nco_real_to_iq_mixer #(
  parameter int SAMPLE_WIDTH    = ncomix_pkg::SAMPLE_WIDTH_DEF,
  parameter int PHASE_WIDTH     = ncomix_pkg::PHASE_WIDTH_DEF,
  parameter int TABLE_ADDR_BITS = ncomix_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Phase step register write
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ncomix_pkg::STEP_W-1:0]         cfg_phase_step,
  // Sample input
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]        in_sample,
  // IQ result
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]        out_i_out,
  output logic signed [SAMPLE_WIDTH-1:0]        out_q_out
);
  import ncomix_pkg::*;

  localparam int ROM_AW    = TABLE_ADDR_BITS - 2;
  localparam int ROM_DEPTH = 1 << ROM_AW;
  localparam int PROD_W    = SAMPLE_WIDTH + COEF_W;
  localparam int RES_W     = SAMPLE_WIDTH + 1;
  localparam int EXT_W     = 48;

  // Quarter-wave sine ROM, fixed at elaboration.
  coef_mag_t rom_tbl [ROM_DEPTH];

  for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_rom
    assign rom_tbl[k] = qsin_entry(k, TABLE_ADDR_BITS);
  end

  // Registers
  logic [STEP_W-1:0]             step_r;
  logic [PHASE_WIDTH-1:0]        phase_r;
  logic [PHASE_WIDTH-1:0]        phase_nxt;
  logic                          v1_r;
  logic                          v2_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] sample1_r;
  logic                          neg_i1_r;
  logic                          neg_q1_r;
  coef_mag_t                     mag_i1_r;
  coef_mag_t                     mag_q1_r;
  logic signed [PROD_W-1:0]      prod_i_r;
  logic signed [PROD_W-1:0]      prod_q_r;
  logic signed [PROD_W-1:0]      prod_i_nxt;
  logic signed [PROD_W-1:0]      prod_q_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_i_r;
  logic signed [SAMPLE_WIDTH-1:0] out_q_r;
  logic signed [SAMPLE_WIDTH-1:0] out_i_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_q_nxt;

  // Stage enables: a stage loads when it is empty or its successor moves on.
  logic en_o;
  logic en2;
  logic en1;
  logic in_acc;

  assign en_o   = !out_valid_r || out_ready;
  assign en2    = !v2_r || en_o;
  assign en1    = !v1_r || en2;
  assign in_acc = in_valid && in_ready;

  assign in_ready  = en1;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_i_out = out_i_r;
  assign out_q_out = out_q_r;

  // Table addressing from the top phase bits.
  logic [TABLE_ADDR_BITS-1:0] taddr;
  logic [1:0]                 quad;
  logic [1:0]                 quad_c;
  logic [ROM_AW-1:0]          idx;
  logic [ROM_AW-1:0]          idx_c;
  logic [ROM_AW-1:0]          idx_s;
  logic [EXT_W-1:0]           step_ext;
  logic [PHASE_WIDTH-1:0]     inc;

  always_comb begin
    taddr    = phase_r[PHASE_WIDTH-1 -: TABLE_ADDR_BITS];
    quad     = taddr[TABLE_ADDR_BITS-1 -: 2];
    idx      = taddr[ROM_AW-1:0];
    // Cosine is the sine one quadrant ahead.
    quad_c   = quad + 2'd1;
    idx_c    = quad_c[0] ? ~idx : idx;
    idx_s    = quad[0] ? ~idx : idx;
    // The step sits at the top of a 48-bit phase; keep the top bits.
    step_ext = {step_r, 16'd0};
    inc      = step_ext[EXT_W-1 -: PHASE_WIDTH];
    phase_nxt = phase_r + inc;
  end

  // Phase step register and phase accumulator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      phase_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        step_r <= cfg_phase_step;
      end
      if (in_acc) begin
        phase_r <= phase_nxt;
      end
    end
  end

  // Stage 1: ROM read of both coefficients, sign flags and sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      sample1_r <= in_sample;
      mag_i1_r  <= rom_tbl[idx_c];
      mag_q1_r  <= rom_tbl[idx_s];
      neg_i1_r  <= quad_c[1];
      // Q uses minus the sine.
      neg_q1_r  <= !quad[1];
    end
  end

  // Stage 2: signed coefficients times the sample.
  coef_t coef_i;
  coef_t coef_q;

  always_comb begin
    coef_i     = neg_i1_r ? -$signed(mag_i1_r) : $signed(mag_i1_r);
    coef_q     = neg_q1_r ? -$signed(mag_q1_r) : $signed(mag_q1_r);
    prod_i_nxt = $signed({{COEF_W{sample1_r[SAMPLE_WIDTH-1]}}, sample1_r})
               * $signed({{SAMPLE_WIDTH{coef_i[COEF_W-1]}}, coef_i});
    prod_q_nxt = $signed({{COEF_W{sample1_r[SAMPLE_WIDTH-1]}}, sample1_r})
               * $signed({{SAMPLE_WIDTH{coef_q[COEF_W-1]}}, coef_q});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      prod_i_r <= prod_i_nxt;
      prod_q_r <= prod_q_nxt;
    end
  end

  // Stage 3: round half up, drop 15 fraction bits, saturate.
  function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W-1:0] rnd;
    logic signed [PROD_W-1:0] shf;
    logic signed [RES_W-1:0]  r;
    logic signed [RES_W-1:0]  hi;
    logic signed [RES_W-1:0]  lo;
    rnd = p + $signed(PROD_W'(1) << (COEF_W - 2));
    shf = rnd >>> (COEF_W - 1);
    r   = shf[RES_W-1:0];
    hi  = $signed({2'b00, {(SAMPLE_WIDTH-1){1'b1}}});
    lo  = $signed({2'b11, {(SAMPLE_WIDTH-1){1'b0}}});
    if (r > hi) begin
      r = hi;
    end else if (r < lo) begin
      r = lo;
    end
    return r[SAMPLE_WIDTH-1:0];
  endfunction

  always_comb begin
    out_i_nxt = round_sat(prod_i_r);
    out_q_nxt = round_sat(prod_q_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_o) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      out_i_r <= out_i_nxt;
      out_q_r <= out_q_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // The phase moves by exactly one step per accepted item.
  a_phase_adv: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> phase_r == $past(phase_nxt))
    else $error("phase did not advance by the step on an accepted item");

  // Without an accepted item the phase holds.
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(phase_r))
    else $error("phase changed without an accepted item");

  // Input back-pressure only when every stage holds an item.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v1_r && v2_r && out_valid_r && !out_ready))
    else $error("input stalled while the pipeline has room");

  // A new result only comes from an item in the multiply stage.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v2_r))
    else $error("result appeared without an item in flight");
`endif

endmodule

FILE: sim/nco_real_to_iq_mixer_tb.sv
// ----------------------------------------------------------------------------
// NCO real-to-IQ mixer testbench
// Streams signed samples into the mixer under several phase step settings and
// idle patterns, predicts each I/Q item from a local phase accumulator and
// quarter-wave sine table, and compares every output item in order.
// ----------------------------------------------------------------------------
module nco_real_to_iq_mixer_tb;

  localparam int SW         = ncomix_pkg::SAMPLE_WIDTH_DEF;
  localparam int PW         = ncomix_pkg::PHASE_WIDTH_DEF;
  localparam int TAB        = ncomix_pkg::TABLE_ADDR_BITS_DEF;
  localparam int STEP_W     = ncomix_pkg::STEP_W;
  localparam int ROM_DEPTH  = 1 << (TAB - 2);
  localparam int CLK_PERIOD = 12;

  // Q30 angle scale and the Q1.15 full-scale coefficient.
  localparam longint unsigned PI_Q30    = 64'd3373259426;
  localparam longint unsigned COEF_FULL = 64'd32767;

  localparam longint SAT_HI = (64'sd1 <<< (SW - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  // Phase steps of the randomized phases; flagged entries get a random step.
  localparam int RAND_PHASES = 9;
  localparam logic [STEP_W-1:0] STEP_PLAN [RAND_PHASES] = '{
    32'h0040_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001,
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000
  };
  localparam logic [RAND_PHASES-1:0] RAND_STEP_MASK = 9'b1_1010_0100;
  localparam int ITEMS_PER_PHASE = 45;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic signed [SW-1:0] i_val;
    logic signed [SW-1:0] q_val;
  } iq_pair_t;

  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     cfg_valid      = 1'b0;
  logic                     cfg_ready;
  logic [STEP_W-1:0]        cfg_phase_step = '0;
  logic                     in_valid       = 1'b0;
  logic                     in_ready;
  logic signed [SW-1:0]     in_sample      = '0;
  logic                     out_valid;
  logic                     out_ready      = 1'b0;
  logic signed [SW-1:0]     out_i_out;
  logic signed [SW-1:0]     out_q_out;

  // Local copy of the mixer state and configuration.
  logic [15:0]              quarter_rom [ROM_DEPTH];
  logic [PW-1:0]            nco_phase;
  logic [STEP_W-1:0]        phase_step_model = '0;
  logic [63:0]              phase_inc;
  logic [TAB-1:0]           mix_addr;

  logic signed [SW-1:0]     pending_samples [$];
  iq_pair_t                 iq_expected_q [$];
  iq_pair_t                 pred_iq;
  iq_pair_t                 head_iq;

  int                       send_idle_pct  = 0;
  int                       recv_stall_pct = 0;
  int                       samples_queued = 0;
  int                       results_seen   = 0;
  int                       mismatch_cnt   = 0;

  nco_real_to_iq_mixer u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_phase_step (cfg_phase_step),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_i_out      (out_i_out),
    .out_q_out      (out_q_out)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Quarter-wave sine entry from an integer Q30 Taylor series, rounded half up.
  function automatic logic [15:0] taylor_quarter_sine(input int unsigned k);
    longint unsigned ang;
    longint unsigned ang2;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned sum;
    longint unsigned mag;
    ang  = (PI_Q30 * (64'(2 * k) + 64'd1)) / 64'(4 * ROM_DEPTH);
    ang2 = (ang * ang) >> 30;
    term = ang;
    pos  = ang;
    neg  = 64'd0;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * ang2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        neg += term;
      end else begin
        pos += term;
      end
    end
    sum = (pos > neg) ? pos - neg : 64'd0;
    mag = (sum * COEF_FULL + (64'd1 << 29)) >> 30;
    if (mag > COEF_FULL) begin
      mag = COEF_FULL;
    end
    return mag[15:0];
  endfunction

  // Signed sine of a table address, folded from the quarter-wave table.
  function automatic int sine_lookup(input logic [TAB-1:0] addr);
    logic [1:0]  quad;
    int unsigned idx;
    int          mag;
    quad = addr[TAB-1 -: 2];
    idx  = addr[TAB-3:0];
    if (quad[0]) begin
      idx = ROM_DEPTH - 1 - idx;
    end
    mag = int'(quarter_rom[idx]);
    return quad[1] ? -mag : mag;
  endfunction

  // Q1.15 product with round half up and saturation to the sample width.
  function automatic logic signed [SW-1:0] mix_product(input logic signed [SW-1:0] x,
                                                       input int coef);
    longint prod;
    prod = longint'(x) * longint'(coef) + 64'sd16384;
    prod = prod >>> 15;
    if (prod > SAT_HI) begin
      prod = SAT_HI;
    end else if (prod < SAT_LO) begin
      prod = SAT_LO;
    end
    return prod[SW-1:0];
  endfunction

  // Random sample, with extra weight on the extremes, zero and minus one.
  function automatic logic signed [SW-1:0] random_sample();
    logic signed [SW-1:0] s;
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0:       s = SAT_LO[SW-1:0];
        1:       s = SAT_HI[SW-1:0];
        2:       s = '0;
        default: s = '1;
      endcase
    end else begin
      s = SW'($urandom);
    end
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic queue_sample(input logic signed [SW-1:0] s);
    pending_samples.push_back(s);
    samples_queued++;
  endtask

  task automatic set_idle_mode(input idle_mode_t mode);
    case (mode)
      IDLE_SEND: begin
        send_idle_pct  <= 77;
        recv_stall_pct <= 0;
      end
      IDLE_RECV: begin
        send_idle_pct  <= 0;
        recv_stall_pct <= 77;
      end
      IDLE_BOTH: begin
        send_idle_pct  <= 13;
        recv_stall_pct <= 13;
      end
      default: begin
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
      end
    endcase
  endtask

  // Called at a rising edge while the mixer is idle.
  task automatic write_phase_step(input logic [STEP_W-1:0] val);
    cfg_phase_step <= val;
    cfg_valid      <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid        <= 1'b0;
    phase_step_model  = val;
  endtask

  // Wait until every queued item has produced its result, plus pipeline slack.
  task automatic wait_drained();
    while (results_seen != samples_queued) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  // Driver: presents queued items and predicts the result of each accepted one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_sample <= '0;
      nco_phase  = '0;
    end else begin
      if (in_valid && in_ready) begin
        mix_addr      = nco_phase[PW-1 -: TAB];
        pred_iq.i_val = mix_product(in_sample, sine_lookup(mix_addr + TAB'(ROM_DEPTH)));
        pred_iq.q_val = mix_product(in_sample, -sine_lookup(mix_addr));
        iq_expected_q.push_back(pred_iq);
        phase_inc = (64'(phase_step_model) << 16) >> (48 - PW);
        nco_phase = nco_phase + phase_inc[PW-1:0];
      end
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid  <= 1'b1;
          in_sample <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: applies back-pressure and checks each output item in order.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (iq_expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected IQ item i=%0d q=%0d", out_i_out, out_q_out));
        end else begin
          head_iq = iq_expected_q.pop_front();
          results_seen++;
          if (out_i_out !== head_iq.i_val) begin
            report_mismatch($sformatf("item %0d: i_out %0d, predicted %0d",
                                      results_seen, out_i_out, head_iq.i_val));
          end
          if (out_q_out !== head_iq.q_val) begin
            report_mismatch($sformatf("item %0d: q_out %0d, predicted %0d",
                                      results_seen, out_q_out, head_iq.q_val));
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stimulus sequence.
  initial begin
    logic [STEP_W-1:0] step_val;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      quarter_rom[k] = taylor_quarter_sine(k);
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset step of zero: every item is mixed at theta zero.
    set_idle_mode(IDLE_NONE);
    queue_sample(SAT_LO[SW-1:0]);
    queue_sample(SAT_HI[SW-1:0]);
    queue_sample('0);
    queue_sample('1);
    queue_sample(16'sd1);
    queue_sample(16'sd16384);
    queue_sample(-16'sd16384);
    wait_drained();

    // Quarter-turn steps land on every quadrant boundary in turn.
    write_phase_step(32'h4000_0000);
    repeat (4) queue_sample(SAT_LO[SW-1:0]);
    repeat (4) queue_sample(SAT_HI[SW-1:0]);
    queue_sample(16'h5555);
    queue_sample(16'hAAAA);
    wait_drained();

    // Eighth-turn steps hit the diagonals with full-scale samples.
    write_phase_step(32'h2000_0000);
    for (int n = 0; n < 8; n++) begin
      queue_sample((n % 2 == 0) ? SAT_LO[SW-1:0] : SAT_HI[SW-1:0]);
    end
    wait_drained();

    // Randomized phases with varied steps and idle patterns.
    for (int p = 0; p < RAND_PHASES; p++) begin
      step_val = RAND_STEP_MASK[p] ? STEP_W'($urandom) : STEP_PLAN[p];
      write_phase_step(step_val);
      set_idle_mode(idle_mode_t'(p % 4));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        queue_sample(random_sample());
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (iq_expected_q.size() != 0) begin
      report_mismatch($sformatf("%0d IQ items never arrived", iq_expected_q.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("nco_real_to_iq_mixer test passed");
    end else begin
      $display("nco_real_to_iq_mixer test failed");
    end
    $finish;
  end

  // Watchdog against a stalled pipeline.
  initial begin
    #(CLK_PERIOD * 300000);
    $display("nco_real_to_iq_mixer test failed");
    $finish;
  end

endmodule

FILE: sim.f
src/ncomix_pkg.sv
src/nco_real_to_iq_mixer.sv
sim/nco_real_to_iq_mixer_tb.sv
